// File: sv/cll_pkg.sv
`timescale 1ns / 1ps

package cll_pkg;

    // Fixed field widths on the stream ports.
    localparam int ELEM_W      = 12;
    localparam int CHAIN_W     = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ELEM_W - CHAIN_W;

    // The chain length saturates at the top of its field.
    localparam logic [CHAIN_W-1:0] CHAIN_MAX = {CHAIN_W{1'b1}};

    typedef logic [ELEM_W-1:0]  t_elem;
    typedef logic [CHAIN_W-1:0] t_chain;

endpackage

// File: sv/circular_lis_lengths_unit.sv
`timescale 1ns / 1ps

// Circular longest-increasing-chain unit. Requests on the slave stream carry one
// sequence element each (value in tdata, tlast on the final element). Elements are
// taken one per cycle into an internal memory of MAX_ITEMS entries; elements past
// that capacity are dropped and flagged. When the tlast request arrives the unit
// drops tready, reads the stored sequence circularly starting at its smallest value
// (the earliest one on a tie), and runs the quadratic dynamic program with a single
// shared compare/increment unit: for the n stored elements the pass visits every
// (i, j) pair with j < i in turn, plus memory-read and write-back steps per
// position, all set by the single read port of the value and chain memories.
// It then sends n result requests in rotated order, reading the next one only
// after the previous one is taken, each holding the value, the longest strictly
// increasing chain ending there minus one, and the overflow flag in tuser;
// tlast marks the final result. After the final result is taken the unit is ready
// for a new sequence. No clearing pass is needed after reset.

module circular_lis_lengths_unit #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream: tdata [11:0] element_value, upper bits zero; tlast is_last.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [cll_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tlast,
    // Master stream: tdata [11:0] out_value, [17:12] chain_minus_one, upper zero;
    // tuser [0] overflowed; tlast last_result.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [cll_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import cll_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // Sequencer states.
    localparam logic [2:0] S_LOAD  = 3'd0;  // taking elements
    localparam logic [2:0] S_VI    = 3'd1;  // read the value at rotated position i
    localparam logic [2:0] S_VIW   = 3'd2;  // latch it, start the inner scan
    localparam logic [2:0] S_INNER = 3'd3;  // scan j = 0 .. i-1
    localparam logic [2:0] S_WRITE = 3'd4;  // store the chain length of i
    localparam logic [2:0] S_ORD   = 3'd5;  // read value and chain for result i
    localparam logic [2:0] S_OLAT  = 3'd6;  // load the output register
    localparam logic [2:0] S_OUT   = 3'd7;  // wait for the result to be taken

    logic [2:0]            r_state;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_min_pos;
    logic [VALUE_BITS-1:0] r_min_val;
    logic                  r_ovf;

    // Rotated-order index i and its physical address, and likewise for j.
    logic [IDX_W-1:0]      r_i;
    logic [IDX_W-1:0]      r_ip;
    logic [IDX_W-1:0]      r_j;
    logic [IDX_W-1:0]      r_jp;
    logic                  r_pend;
    logic [VALUE_BITS-1:0] r_vi;
    t_chain                r_best;

    // Memories and their registered read data.
    logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
    t_chain                chain_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_val_rd;
    t_chain                r_chain_rd;

    // Output register.
    logic                  r_out_vld;
    t_elem                 r_out_value;
    t_chain                r_out_chain;
    logic                  r_out_ovf;
    logic                  r_out_last;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_room;
    logic [VALUE_BITS-1:0] w_in_val;
    logic [IDX_W-1:0]      w_val_raddr;
    logic [IDX_W-1:0]      w_chain_raddr;
    logic [IDX_W-1:0]      w_ip_next;
    logic [IDX_W-1:0]      w_jp_next;
    logic                  w_i_last;
    t_chain                w_cand;

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = r_out_vld && i_m_axis_tready;
    assign w_room          = (r_count < CNT_W'(MAX_ITEMS));
    assign w_in_val        = VALUE_BITS'(i_s_axis_tdata[ELEM_W-1:0]);

    // Circular address steps wrap at the number of stored elements.
    assign w_ip_next = (CNT_W'(r_ip) + CNT_W'(1) == r_count) ? '0 : r_ip + IDX_W'(1);
    assign w_jp_next = (CNT_W'(r_jp) + CNT_W'(1) == r_count) ? '0 : r_jp + IDX_W'(1);
    assign w_i_last  = (CNT_W'(r_i) + CNT_W'(1) == r_count);

    // The inner scan reads at j; every other state reads at i.
    assign w_val_raddr   = (r_state == S_INNER) ? r_jp : r_ip;
    assign w_chain_raddr = (r_state == S_INNER) ? r_j  : r_i;

    // Candidate chain length through element j, saturating.
    assign w_cand = (r_chain_rd == CHAIN_MAX) ? CHAIN_MAX : r_chain_rd + CHAIN_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_room) begin
            value_mem[r_count[IDX_W-1:0]] <= w_in_val;
        end
        if (r_state == S_WRITE) begin
            chain_mem[r_i] <= r_best;
        end
        r_val_rd   <= value_mem[w_val_raddr];
        r_chain_rd <= chain_mem[w_chain_raddr];
    end

    // Sequencer and the shared compare unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_min_pos <= '0;
            r_min_val <= '1;
            r_ovf     <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            if (w_in_val < r_min_val) begin
                                r_min_val <= w_in_val;
                                r_min_pos <= r_count[IDX_W-1:0];
                            end
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= S_VI;
                        end
                    end
                    r_i  <= '0;
                    r_ip <= (w_in_acc && w_room && (w_in_val < r_min_val)) ?
                            r_count[IDX_W-1:0] : r_min_pos;
                end
                S_VI: begin
                    r_state <= S_VIW;
                end
                S_VIW: begin
                    r_vi    <= r_val_rd;
                    r_best  <= '0;
                    r_j     <= '0;
                    r_jp    <= r_min_pos;
                    r_pend  <= 1'b0;
                    r_state <= S_INNER;
                end
                S_INNER: begin
                    // Compare the pair whose reads were issued last cycle.
                    if (r_pend && (r_val_rd < r_vi) && (w_cand > r_best)) begin
                        r_best <= w_cand;
                    end
                    if (r_j != r_i) begin
                        r_j    <= r_j + IDX_W'(1);
                        r_jp   <= w_jp_next;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_i_last) begin
                        r_i     <= '0;
                        r_ip    <= r_min_pos;
                        r_state <= S_ORD;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_ip    <= w_ip_next;
                        r_state <= S_VI;
                    end
                end
                S_ORD: begin
                    r_state <= S_OLAT;
                end
                S_OLAT: begin
                    r_out_value <= ELEM_W'(r_val_rd);
                    r_out_chain <= r_chain_rd;
                    r_out_ovf   <= r_ovf;
                    r_out_last  <= w_i_last;
                    r_out_vld   <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        r_out_vld <= 1'b0;
                        if (r_out_last) begin
                            // Run complete: back to the reset state.
                            r_count   <= '0;
                            r_min_pos <= '0;
                            r_min_val <= '1;
                            r_ovf     <= 1'b0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_ip    <= w_ip_next;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_chain, r_out_value};
    assign o_m_axis_tuser  = r_out_ovf;
    assign o_m_axis_tlast  = r_out_last;

    // The unit never takes an element while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while a result is pending");

    // A result is only offered while elements are held.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count != '0))
        else $error("result offered with an empty store");

    // A chain ending at rotated position i cannot be longer than i + 1.
    a_chain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (int'(r_out_chain) <= int'(r_i)))
        else $error("chain length exceeds its position");

    // Taking the final result returns the unit to loading.
    a_return_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (o_s_axis_tready && (r_count == '0)))
        else $error("unit not reset after the final result");

endmodule

// File: dv/circular_lis_lengths_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the circular longest-increasing-chain unit.
module circular_lis_lengths_unit_test;
    import cll_pkg::*;

    localparam int SEQ_CAP         = 64;     // MAX_ITEMS of the instance below
    localparam int ITEM_GOAL       = 410;    // input requests before the stimulus stops
    localparam int QUIET_FROM      = 350;    // no idling on either side after this many
    localparam int HOLD_OFF_AFTER  = 100;    // the long receiver stall comes after this
    localparam int HOLD_OFF_CYCLES = 400;
    // A full run of 64 elements spends its whole pass with no request moving on either
    // side, and the long receiver stall adds its own idle stretch on top.
    localparam int WATCHDOG_LIMIT  = 12000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic [1:0] {RUN_SHORT, RUN_FULL, RUN_OVERFLOW} t_run_kind;
    typedef enum logic [1:0] {VAL_ANY, VAL_NARROW, VAL_RISING} t_value_style;

    // One result request as seen on the master stream.
    typedef struct packed {
        t_elem  value;
        t_chain chain;
        logic   dropped;
        logic   last;
    } t_lis_result;

    // One row of the directed table. Rows with typed set carry their own expected
    // result; these are single-element runs, so the chain is zero, nothing was
    // dropped, and the result is the final one of its run.
    typedef struct packed {
        t_elem  value;
        logic   last;
        logic   typed;
        t_elem  exp_value;
        t_chain exp_chain;
    } t_dir_row;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // [11:0] element_value, upper zero
    logic                   i_s_axis_tlast  = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // [11:0] value, [17:12] chain
    logic                   o_m_axis_tuser;         // [0] overflowed
    logic                   o_m_axis_tlast;

    // Expected results in the order the unit must send them.
    t_lis_result pending_chains[$];

    // Predictor state: the elements of the run being loaded, and whether any
    // element of it was dropped because the store was full.
    t_elem seq_vals[$];
    logic  seq_dropped = 1'b0;

    int items_sent    = 0;
    int mismatches    = 0;
    int stuck_cycles  = 0;
    bit quiet         = 1'b0;
    bit hold_off_done = 1'b0;

    // Directed part: extremes after reset, alternating bit patterns, a repeated
    // minimum where the earliest copy must start the rotation, a falling run that
    // wraps, equal values that never form a chain, and an all-ones run where no
    // element is below the reset minimum.
    t_dir_row dir_table [18] = '{
        '{12'd0,    1'b1, 1'b1, 12'd0,    6'd0},
        '{12'd4095, 1'b1, 1'b1, 12'd4095, 6'd0},
        '{12'hAAA,  1'b1, 1'b1, 12'hAAA,  6'd0},
        '{12'h555,  1'b1, 1'b1, 12'h555,  6'd0},
        '{12'd5,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd2,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd8,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd2,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd6,    1'b1, 1'b0, 12'd0,    6'd0},
        '{12'd4095, 1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd3000, 1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd100,  1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd0,    1'b1, 1'b0, 12'd0,    6'd0},
        '{12'd7,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd7,    1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd7,    1'b1, 1'b0, 12'd0,    6'd0},
        '{12'd4095, 1'b0, 1'b0, 12'd0,    6'd0},
        '{12'd4095, 1'b1, 1'b0, 12'd0,    6'd0}
    };

    circular_lis_lengths_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stores one accepted element and, when it closes a run, works out the whole
    // run: rotate so the earliest smallest value comes first, then for every
    // position take the longest strictly increasing chain ending there. Elements
    // past the store's capacity are only remembered as a dropped flag.
    task automatic track_element(input t_elem value, input logic last, input bit record);
        int    n;
        int    start;
        int    best;
        t_elem rot_vals [SEQ_CAP];
        int    chain_len [SEQ_CAP];
        if (seq_vals.size() < SEQ_CAP) begin
            seq_vals.push_back(value);
        end else begin
            seq_dropped = 1'b1;
        end
        if (!last) begin
            return;
        end
        n = seq_vals.size();
        start = 0;
        for (int k = 1; k < n; k++) begin
            if (seq_vals[k] < seq_vals[start]) begin
                start = k;
            end
        end
        for (int i = 0; i < n; i++) begin
            rot_vals[i] = seq_vals[(start + i) % n];
            best = 0;
            for (int j = 0; j < i; j++) begin
                if (rot_vals[j] < rot_vals[i] && chain_len[j] + 1 > best) begin
                    best = chain_len[j] + 1;
                end
            end
            chain_len[i] = (best > CHAIN_MAX) ? int'(CHAIN_MAX) : best;
            if (record) begin
                pending_chains.push_back(t_lis_result'{rot_vals[i], t_chain'(chain_len[i]),
                                                       seq_dropped, i == n - 1});
            end
        end
        seq_vals.delete();
        seq_dropped = 1'b0;
    endtask

    // Offers one element at the falling edge and holds it until the unit takes it.
    // A random gap may come first; valid stays high from one request to the next
    // when there is none.
    task automatic send_element(input t_elem value, input logic last, input bit record);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'(value);
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if (items_sent >= QUIET_FROM) begin
            quiet = 1'b1;
        end
        track_element(value, last, record);
        @(negedge i_clk);
    endtask

    // Sends one whole run. Rising runs are increasing sequences rotated by a
    // random amount, so the chains grow long and the start is rarely at the front;
    // narrow runs draw from a handful of values so ties are common.
    task automatic send_run(input t_run_kind kind, input t_value_style style);
        int    len;
        int    rot;
        int    k;
        t_elem v;
        case (kind)
            RUN_SHORT: len = $urandom_range(1, 16);
            RUN_FULL:  len = SEQ_CAP;
            default:   len = SEQ_CAP + $urandom_range(1, 4);
        endcase
        rot = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            k = (i + rot) % len;
            case (style)
                VAL_ANY:    v = t_elem'($urandom);
                VAL_NARROW: v = t_elem'($urandom_range(0, 15));
                default:    v = t_elem'((k % SEQ_CAP) * 64 + $urandom_range(0, 63));
            endcase
            send_element(v, i == len - 1, 1'b1);
        end
    endtask

    task automatic note_mismatch(input string what, input t_lis_result want,
                                 input t_lis_result got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected value %0d chain %0d dropped %0b last %0b,",
                     $realtime, what, want.value, want.chain, want.dropped, want.last);
            $display("    got value %0d chain %0d dropped %0b last %0b",
                     got.value, got.chain, got.dropped, got.last);
        end
    endtask

    initial begin : stimulus
        int           run_no;
        t_run_kind    kind;
        t_value_style style;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            send_element(dir_table[r].value, dir_table[r].last, !dir_table[r].typed);
            if (dir_table[r].typed) begin
                pending_chains.push_back(t_lis_result'{dir_table[r].exp_value,
                                                       dir_table[r].exp_chain, 1'b0, 1'b1});
            end
        end

        // Mostly short runs; an overflowing run and a full run early on, both
        // rising so the chain field reaches its top, and more long runs at random.
        run_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if (run_no == 1) begin
                kind = RUN_OVERFLOW;
            end else if (run_no == 3) begin
                kind = RUN_FULL;
            end else if ($urandom_range(0, 11) == 0) begin
                kind = ($urandom_range(0, 1) == 0) ? RUN_FULL : RUN_OVERFLOW;
            end else begin
                kind = RUN_SHORT;
            end
            style = t_value_style'($urandom_range(0, 2));
            if (kind != RUN_SHORT && run_no < 4) begin
                style = VAL_RISING;
            end
            send_run(kind, style);
            run_no++;
        end
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;

        // Wait for every expected result, then a little longer to catch extras.
        while (pending_chains.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_chains.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: random stalls in short bursts, and once a long hold-off while a
    // result is on offer, so the sender's next element waits on a blocked input.
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (!hold_off_done && i_rst_n && o_m_axis_tvalid && items_sent > HOLD_OFF_AFTER) begin
                hold_off_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_lis_result got;
        t_lis_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value   = o_m_axis_tdata[ELEM_W-1:0];
            got.chain   = o_m_axis_tdata[ELEM_W +: CHAIN_W];
            got.dropped = o_m_axis_tuser;
            got.last    = o_m_axis_tlast;
            if (pending_chains.size() == 0) begin
                note_mismatch("result with nothing expected", '0, got);
            end else begin
                want = pending_chains.pop_front();
                if (got != want) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: too long without any request moving on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// File: files.f
sv/cll_pkg.sv
sv/circular_lis_lengths_unit.sv
dv/circular_lis_lengths_unit_test.sv
